// ----- rtl/sscp_pkg.sv -----
// Shared widths, constants and pipeline context type for the segment pair
// closest points unit. No dependencies.
package sscp_pkg;

  localparam int CoordW  = 24;             // Q12.12 coordinate
  localparam int DiffW   = CoordW + 1;     // endpoint difference
  localparam int FracW   = 16;             // fraction bits of s and t
  localparam int ParW    = FracW + 1;      // s and t including the value one
  localparam int ThrW    = 20;
  localparam int DotW    = 2 * DiffW + 2;  // sum of three products, signed
  localparam int MulW    = DotW;           // wide multiplier operand
  localparam int MulHalf = MulW / 2;
  localparam int ProdW   = 2 * MulW;
  localparam int NumW    = ProdW + 1;      // quotient numerator, signed
  localparam int DistW   = 52;
  localparam int PrW     = DiffW + ParW + 1;

  localparam logic [ParW-1:0] ParOne = {1'b1, {FracW{1'b0}}};

  typedef struct packed {
    logic [2:0][CoordW-1:0] p1;
    logic [2:0][CoordW-1:0] p2;
    logic [2:0][DiffW-1:0]  d1;
    logic [2:0][DiffW-1:0]  d2;
  } geo_t;

  typedef struct packed {
    geo_t            geo;
    logic [DotW-1:0] a;
    logic [DotW-1:0] e;
    logic [DotW-1:0] b;
    logic [DotW-1:0] c;
    logic [DotW-1:0] f;
    logic [DotW:0]   negc;   // -c
    logic [DotW:0]   bmc;    // b - c
    logic            dega;
    logic            dege;
    logic [ParW-1:0] s1;     // first quotient
    logic            lt0;    // t numerator below zero
    logic            gt;     // t numerator above its denominator
  } ctx_t;

endpackage

// ----- rtl/sscp_mul.sv -----
// Two-stage signed multiplier built from four half-width partial products.
// Depends on sscp_pkg.
module sscp_mul (
  input  logic                             clk_i,
  input  logic signed [sscp_pkg::MulW-1:0]  a_i,
  input  logic signed [sscp_pkg::MulW-1:0]  b_i,
  output logic signed [sscp_pkg::ProdW-1:0] p_o
);

  localparam int H  = sscp_pkg::MulHalf;
  localparam int HH = sscp_pkg::MulW - sscp_pkg::MulHalf;

  logic [sscp_pkg::MulW-1:0] ma, mb;
  logic [2*H-1:0]            pll_q;
  logic [H+HH-1:0]           plh_q, phl_q;
  logic [2*HH-1:0]           phh_q;
  logic                      neg_q;
  logic [sscp_pkg::ProdW-1:0] sum;
  logic signed [sscp_pkg::ProdW-1:0] p_q;

  assign ma = a_i[sscp_pkg::MulW-1] ? sscp_pkg::MulW'(-a_i) : sscp_pkg::MulW'(a_i);
  assign mb = b_i[sscp_pkg::MulW-1] ? sscp_pkg::MulW'(-b_i) : sscp_pkg::MulW'(b_i);

  always_ff @(posedge clk_i) begin
    pll_q <= ma[H-1:0] * mb[H-1:0];
    plh_q <= ma[H-1:0] * mb[sscp_pkg::MulW-1:H];
    phl_q <= ma[sscp_pkg::MulW-1:H] * mb[H-1:0];
    phh_q <= ma[sscp_pkg::MulW-1:H] * mb[sscp_pkg::MulW-1:H];
    neg_q <= a_i[sscp_pkg::MulW-1] ^ b_i[sscp_pkg::MulW-1];
  end

  assign sum = sscp_pkg::ProdW'(pll_q)
             + ((sscp_pkg::ProdW'(plh_q) + sscp_pkg::ProdW'(phl_q)) << H)
             + (sscp_pkg::ProdW'(phh_q) << (2 * H));

  always_ff @(posedge clk_i) begin
    p_q <= neg_q ? $signed(-sum) : $signed(sum);
  end

  assign p_o = p_q;

endmodule

// ----- rtl/sscp_div.sv -----
// Pipelined clamped quotient num/den in Q1.16, one quotient bit per stage.
// Depends on sscp_pkg.
module sscp_div (
  input  logic                             clk_i,
  input  logic signed [sscp_pkg::NumW-1:0] num_i,
  input  logic [sscp_pkg::ProdW-1:0]       den_i,
  input  logic                             zero_i,
  output logic [sscp_pkg::ParW-1:0]        q_o
);

  localparam int N = sscp_pkg::FracW;

  logic [sscp_pkg::NumW-1:0]  rem_q [0:N];
  logic [sscp_pkg::ProdW-1:0] den_q [0:N];
  logic [N-1:0]               q_q   [0:N];
  logic                       z_q   [0:N];
  logic                       o_q   [0:N];

  logic [sscp_pkg::NumW-1:0]  rem_sh [1:N];
  logic                       ge     [1:N];
  logic                       z0;

  assign z0 = zero_i || (num_i <= 0);

  always_comb begin
    for (int k = 1; k <= N; k++) begin
      rem_sh[k] = rem_q[k-1] << 1;
      ge[k]     = rem_sh[k] >= sscp_pkg::NumW'(den_q[k-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= $unsigned(num_i);
    den_q[0] <= den_i;
    q_q[0]   <= '0;
    z_q[0]   <= z0;
    o_q[0]   <= !z0 && ($unsigned(num_i) >= sscp_pkg::NumW'(den_i));
    for (int k = 1; k <= N; k++) begin
      rem_q[k] <= ge[k] ? rem_sh[k] - sscp_pkg::NumW'(den_q[k-1]) : rem_sh[k];
      den_q[k] <= den_q[k-1];
      q_q[k]   <= {q_q[k-1][N-2:0], ge[k]};
      z_q[k]   <= z_q[k-1];
      o_q[k]   <= o_q[k-1];
    end
  end

  assign q_o = z_q[N] ? '0 : (o_q[N] ? sscp_pkg::ParOne : {1'b0, q_q[N]});

endmodule

// ----- rtl/segment_segment_closest_points_unit.sv -----
// Closest points between two 3D segments, fully pipelined.
// Depends on sscp_pkg, sscp_mul and sscp_div.
//
// Usage:
//  - A segment pair is taken at each rising edge with start high and busy
//    low. busy is always low: a new pair may follow every cycle.
//  - The result sits on the result ports for one cycle with done_o high,
//    and is taken at the edge that ends that cycle. Throughput is one pair per cycle.
//  - Latency is set by the two 17-stage quotient pipelines (one bit per
//    stage) plus dot product, wide multiply, t numerator and near point stages.
//  - The receiver cannot stall; each result must be sampled while done_o is
//    high.
//  - The degenerate threshold is written through cfg_valid_i/cfg_data_i
//    (cfg_ready_o is always high); the user must write it only while no pair is in flight, unenforced by the block.
//  - Reset clears the valid line and the threshold; no clearing pass.
module segment_segment_closest_points_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [sscp_pkg::CoordW-1:0]  p1_x_i,
  input  logic signed [sscp_pkg::CoordW-1:0]  p1_y_i,
  input  logic signed [sscp_pkg::CoordW-1:0]  p1_z_i,
  input  logic signed [sscp_pkg::CoordW-1:0]  q1_x_i,
  input  logic signed [sscp_pkg::CoordW-1:0]  q1_y_i,
  input  logic signed [sscp_pkg::CoordW-1:0]  q1_z_i,
  input  logic signed [sscp_pkg::CoordW-1:0]  p2_x_i,
  input  logic signed [sscp_pkg::CoordW-1:0]  p2_y_i,
  input  logic signed [sscp_pkg::CoordW-1:0]  p2_z_i,
  input  logic signed [sscp_pkg::CoordW-1:0]  q2_x_i,
  input  logic signed [sscp_pkg::CoordW-1:0]  q2_y_i,
  input  logic signed [sscp_pkg::CoordW-1:0]  q2_z_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sscp_pkg::ThrW-1:0]           cfg_data_i,
  output logic                                done_o,
  output logic [sscp_pkg::DistW-1:0]          dist_sq_o,
  output logic signed [sscp_pkg::CoordW-1:0]  near1_x_o,
  output logic signed [sscp_pkg::CoordW-1:0]  near1_y_o,
  output logic signed [sscp_pkg::CoordW-1:0]  near1_z_o,
  output logic signed [sscp_pkg::CoordW-1:0]  near2_x_o,
  output logic signed [sscp_pkg::CoordW-1:0]  near2_y_o,
  output logic signed [sscp_pkg::CoordW-1:0]  near2_z_o,
  output logic [sscp_pkg::ParW-1:0]           param_s_o,
  output logic [sscp_pkg::ParW-1:0]           param_t_o
);

  localparam int CW = sscp_pkg::CoordW;
  localparam int DW = sscp_pkg::DiffW;
  localparam int TW = sscp_pkg::DotW;
  localparam int NW = sscp_pkg::NumW;
  localparam int PW = sscp_pkg::ParW;
  localparam int FW = sscp_pkg::FracW;
  localparam int RW = sscp_pkg::PrW;
  localparam int Last = 49;

  logic [sscp_pkg::ThrW-1:0] thr_q;
  logic                      v_q [1:Last];

  logic signed [CW-1:0] p1_in [3], q1_in [3], p2_in [3], q2_in [3];

  sscp_pkg::geo_t geo1_q, geo2_q, geo3_q;
  logic [2:0][DW-1:0] r1_q;

  logic signed [2*DW-1:0] paa_q [3], pee_q [3], pbb_q [3], pcc_q [3], pff_q [3];
  logic signed [TW-1:0] a3_q, e3_q, b3_q, c3_q, f3_q;

  sscp_pkg::ctx_t ctx_q [4:45];
  sscp_pkg::ctx_t ctx_d [5:45];

  logic signed [sscp_pkg::ProdW-1:0] ae5, bb5, bf5, ce5;
  logic signed [NW-1:0] denom_q, numg_q;

  logic signed [NW-1:0]       dv1_num, dv2_num;
  logic [sscp_pkg::ProdW-1:0] dv1_den, dv2_den;
  logic                       dv1_zero, dv2_zero;
  logic [PW-1:0]              q1, q2;

  logic signed [TW+PW:0] bs_q;
  logic signed [NW-1:0]  tn_q, td_q, tn26_q, td26_q;

  logic [PW-1:0] s_q [44:Last];
  logic [PW-1:0] t_q [44:Last];
  logic [PW-1:0] s44_d, t44_d;

  logic signed [RW-1:0] pr1_q [3], pr2_q [3];
  logic signed [RW-1:0] adj1 [3], adj2 [3];
  logic [2:0][CW-1:0] n1_q [46:Last];
  logic [2:0][CW-1:0] n2_q [46:Last];
  logic signed [DW-1:0] diff_q [3];
  logic signed [2*DW-1:0] sq_q [3];
  logic [sscp_pkg::DistW-1:0] dist_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  assign p1_in[0] = p1_x_i; assign p1_in[1] = p1_y_i; assign p1_in[2] = p1_z_i;
  assign q1_in[0] = q1_x_i; assign q1_in[1] = q1_y_i; assign q1_in[2] = q1_z_i;
  assign p2_in[0] = p2_x_i; assign p2_in[1] = p2_y_i; assign p2_in[2] = p2_z_i;
  assign q2_in[0] = q2_x_i; assign q2_in[1] = q2_y_i; assign q2_in[2] = q2_z_i;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
      for (int k = 1; k <= Last; k++) v_q[k] <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) thr_q <= cfg_data_i;
      v_q[1] <= start && !busy;
      for (int k = 2; k <= Last; k++) v_q[k] <= v_q[k-1];
    end
  end

  // stages 1 to 3: differences, products, dot products
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      geo1_q.p1[i] <= p1_in[i];
      geo1_q.p2[i] <= p2_in[i];
      geo1_q.d1[i] <= DW'(q1_in[i]) - DW'(p1_in[i]);
      geo1_q.d2[i] <= DW'(q2_in[i]) - DW'(p2_in[i]);
      r1_q[i]      <= DW'(p1_in[i]) - DW'(p2_in[i]);
      paa_q[i] <= $signed(geo1_q.d1[i]) * $signed(geo1_q.d1[i]);
      pee_q[i] <= $signed(geo1_q.d2[i]) * $signed(geo1_q.d2[i]);
      pbb_q[i] <= $signed(geo1_q.d1[i]) * $signed(geo1_q.d2[i]);
      pcc_q[i] <= $signed(geo1_q.d1[i]) * $signed(r1_q[i]);
      pff_q[i] <= $signed(geo1_q.d2[i]) * $signed(r1_q[i]);
    end
    geo2_q <= geo1_q;
    geo3_q <= geo2_q;
    a3_q <= TW'(paa_q[0]) + TW'(paa_q[1]) + TW'(paa_q[2]);
    e3_q <= TW'(pee_q[0]) + TW'(pee_q[1]) + TW'(pee_q[2]);
    b3_q <= TW'(pbb_q[0]) + TW'(pbb_q[1]) + TW'(pbb_q[2]);
    c3_q <= TW'(pcc_q[0]) + TW'(pcc_q[1]) + TW'(pcc_q[2]);
    f3_q <= TW'(pff_q[0]) + TW'(pff_q[1]) + TW'(pff_q[2]);
  end

  // stage 4: classify, then the context travels alongside the arithmetic
  always_ff @(posedge clk_i) begin
    ctx_q[4].geo  <= geo3_q;
    ctx_q[4].a    <= a3_q;
    ctx_q[4].e    <= e3_q;
    ctx_q[4].b    <= b3_q;
    ctx_q[4].c    <= c3_q;
    ctx_q[4].f    <= f3_q;
    ctx_q[4].negc <= (TW+1)'(0) - (TW+1)'(c3_q);
    ctx_q[4].bmc  <= (TW+1)'(b3_q) - (TW+1)'(c3_q);
    ctx_q[4].dega <= $unsigned(a3_q) <= TW'(thr_q);
    ctx_q[4].dege <= $unsigned(e3_q) <= TW'(thr_q);
    ctx_q[4].s1   <= '0;
    ctx_q[4].lt0  <= 1'b0;
    ctx_q[4].gt   <= 1'b0;
    for (int k = 5; k <= 45; k++) ctx_q[k] <= ctx_d[k];
  end

  always_comb begin
    for (int k = 5; k <= 45; k++) ctx_d[k] = ctx_q[k-1];
    ctx_d[24].s1  = q1;
    ctx_d[26].lt0 = tn_q[NW-1];
    ctx_d[26].gt  = tn_q > td_q;
  end

  // stages 4 and 5: wide products
  sscp_mul u_mul_ae (.clk_i(clk_i), .a_i(a3_q), .b_i(e3_q), .p_o(ae5));
  sscp_mul u_mul_bb (.clk_i(clk_i), .a_i(b3_q), .b_i(b3_q), .p_o(bb5));
  sscp_mul u_mul_bf (.clk_i(clk_i), .a_i(b3_q), .b_i(f3_q), .p_o(bf5));
  sscp_mul u_mul_ce (.clk_i(clk_i), .a_i(c3_q), .b_i(e3_q), .p_o(ce5));

  always_ff @(posedge clk_i) begin
    denom_q <= NW'(ae5) - NW'(bb5);
    numg_q  <= NW'(bf5) - NW'(ce5);
  end

  // first quotient: s in the general and second-degenerate cases, t when
  // the first segment is a point
  always_comb begin
    dv1_num  = numg_q;
    dv1_den  = sscp_pkg::ProdW'($unsigned(denom_q));
    dv1_zero = 1'b0;
    case ({ctx_q[6].dega, ctx_q[6].dege})
      2'b00: begin
        dv1_zero = denom_q == '0;
      end
      2'b10: begin
        dv1_num = NW'($signed(ctx_q[6].f));
        dv1_den = sscp_pkg::ProdW'(ctx_q[6].e);
      end
      2'b01: begin
        dv1_num = NW'($signed(ctx_q[6].negc));
        dv1_den = sscp_pkg::ProdW'(ctx_q[6].a);
      end
      default: begin
        dv1_zero = 1'b1;
      end
    endcase
  end

  sscp_div u_div_first (
    .clk_i (clk_i),
    .num_i (dv1_num),
    .den_i (dv1_den),
    .zero_i(dv1_zero),
    .q_o   (q1)
  );

  // stages 24 to 26: t numerator and clamp decision
  always_ff @(posedge clk_i) begin
    bs_q   <= $signed(ctx_q[23].b) * $signed({1'b0, q1});
    tn_q   <= NW'(bs_q) + (NW'($signed(ctx_q[24].f)) <<< FW);
    td_q   <= $signed(NW'(ctx_q[24].e) << FW);
    tn26_q <= tn_q;
    td26_q <= td_q;
  end

  always_comb begin
    dv2_zero = ctx_q[26].dega || ctx_q[26].dege;
    if (ctx_q[26].lt0) begin
      dv2_num = NW'($signed(ctx_q[26].negc));
      dv2_den = sscp_pkg::ProdW'(ctx_q[26].a);
    end else if (ctx_q[26].gt) begin
      dv2_num = NW'($signed(ctx_q[26].bmc));
      dv2_den = sscp_pkg::ProdW'(ctx_q[26].a);
    end else begin
      dv2_num = tn26_q;
      dv2_den = sscp_pkg::ProdW'($unsigned(td26_q));
    end
  end

  sscp_div u_div_second (
    .clk_i (clk_i),
    .num_i (dv2_num),
    .den_i (dv2_den),
    .zero_i(dv2_zero),
    .q_o   (q2)
  );

  // stage 44: final s and t
  always_comb begin
    s44_d = '0;
    t44_d = '0;
    case ({ctx_q[43].dega, ctx_q[43].dege})
      2'b00: begin
        if (ctx_q[43].lt0) begin
          s44_d = q2;
        end else if (ctx_q[43].gt) begin
          s44_d = q2;
          t44_d = sscp_pkg::ParOne;
        end else begin
          s44_d = ctx_q[43].s1;
          t44_d = q2;
        end
      end
      2'b10: begin
        t44_d = ctx_q[43].s1;
      end
      2'b01: begin
        s44_d = ctx_q[43].s1;
      end
      default: begin
        s44_d = '0;
      end
    endcase
  end

  // near points, truncating toward zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      adj1[i] = pr1_q[i] + (pr1_q[i][RW-1] ? RW'({FW{1'b1}}) : RW'(0));
      adj2[i] = pr2_q[i] + (pr2_q[i][RW-1] ? RW'({FW{1'b1}}) : RW'(0));
    end
  end

  always_ff @(posedge clk_i) begin
    s_q[44] <= s44_d;
    t_q[44] <= t44_d;
    for (int k = 45; k <= Last; k++) begin
      s_q[k] <= s_q[k-1];
      t_q[k] <= t_q[k-1];
    end
    for (int k = 47; k <= Last; k++) begin
      n1_q[k] <= n1_q[k-1];
      n2_q[k] <= n2_q[k-1];
    end
    for (int i = 0; i < 3; i++) begin
      pr1_q[i]   <= $signed(ctx_q[44].geo.d1[i]) * $signed({1'b0, s_q[44]});
      pr2_q[i]   <= $signed(ctx_q[44].geo.d2[i]) * $signed({1'b0, t_q[44]});
      n1_q[46][i] <= CW'($signed(ctx_q[45].geo.p1[i]) + CW'(adj1[i] >>> FW));
      n2_q[46][i] <= CW'($signed(ctx_q[45].geo.p2[i]) + CW'(adj2[i] >>> FW));
      diff_q[i]  <= DW'($signed(n1_q[46][i])) - DW'($signed(n2_q[46][i]));
      sq_q[i]    <= diff_q[i] * diff_q[i];
    end
    dist_q <= sscp_pkg::DistW'($unsigned(sq_q[0])) + sscp_pkg::DistW'($unsigned(sq_q[1]))
            + sscp_pkg::DistW'($unsigned(sq_q[2]));
  end

  assign done_o    = v_q[Last];
  assign dist_sq_o = dist_q;
  assign near1_x_o = n1_q[Last][0];
  assign near1_y_o = n1_q[Last][1];
  assign near1_z_o = n1_q[Last][2];
  assign near2_x_o = n2_q[Last][0];
  assign near2_y_o = n2_q[Last][1];
  assign near2_z_o = n2_q[Last][2];
  assign param_s_o = s_q[Last];
  assign param_t_o = t_q[Last];

  // squared length is never negative
  a_len_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[4] |-> !ctx_q[4].a[TW-1] && !ctx_q[4].e[TW-1])
    else $error("negative squared length");

  a_denom_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[6] |-> !denom_q[NW-1])
    else $error("negative denominator");

  a_clamp_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[26] |-> !(ctx_q[26].lt0 && ctx_q[26].gt))
    else $error("both t clamps taken");

  a_param_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (param_s_o <= sscp_pkg::ParOne) && (param_t_o <= sscp_pkg::ParOne))
    else $error("parameter above one");

endmodule

// ----- tb/sscp_scoreboard.sv -----
// Checker for the segment pair closest points unit: watches the pair,
// threshold and result channels, predicts each result and compares it.
// Depends on sscp_pkg.
`timescale 1ns / 1ps

module sscp_scoreboard (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  input  logic                                   busy,
  input  logic [11:0][sscp_pkg::CoordW-1:0]      pair_i,
  input  logic                                   cfg_valid_i,
  input  logic                                   cfg_ready_i,
  input  logic [sscp_pkg::ThrW-1:0]              cfg_data_i,
  input  logic                                   done_i,
  input  logic [sscp_pkg::DistW-1:0]             dist_sq_i,
  input  logic [5:0][sscp_pkg::CoordW-1:0]       near_i,
  input  logic [sscp_pkg::ParW-1:0]              param_s_i,
  input  logic [sscp_pkg::ParW-1:0]              param_t_i,
  output int                                     fail_count_o,
  output int                                     pending_o
);

  localparam int CoordW = sscp_pkg::CoordW;
  localparam int DistW  = sscp_pkg::DistW;
  localparam int ParW   = sscp_pkg::ParW;
  localparam int ThrW   = sscp_pkg::ThrW;
  localparam int FracW  = sscp_pkg::FracW;
  localparam logic [ParW-1:0] ParOne = sscp_pkg::ParOne;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic [DistW-1:0]        dsq;
    logic [5:0][CoordW-1:0]  near;
    logic [ParW-1:0]         s;
    logic [ParW-1:0]         t;
  } closest_t;

  closest_t        closest_q[$];
  logic [ThrW-1:0] thr_q;

  assign pending_o = closest_q.size();

  function automatic wide_t dot3(longint u[3], longint v[3]);
    wide_t acc;
    acc = '0;
    for (int i = 0; i < 3; i++) acc += wide_t'(u[i]) * wide_t'(v[i]);
    return acc;
  endfunction

  // clamped n/d in Q1.16, d positive
  function automatic logic [ParW-1:0] clamp_quot(wide_t n, wide_t d);
    wide_t q;
    if (n <= 0) return '0;
    if (n >= d) return ParOne;
    q = (n <<< FracW) / d;
    return q[ParW-1:0];
  endfunction

  function automatic closest_t predict_closest(logic [11:0][CoordW-1:0] c,
                                               logic [ThrW-1:0] thr);
    longint p1[3], p2[3], d1[3], d2[3], rv[3], n1[3], n2[3], df[3];
    wide_t a, e, f, b, cc, den, tn, td, dd;
    logic [ParW-1:0] s, t;
    logic dega, dege;
    closest_t r;
    for (int i = 0; i < 3; i++) begin
      p1[i] = longint'($signed(c[i]));
      p2[i] = longint'($signed(c[6+i]));
      d1[i] = longint'($signed(c[3+i])) - p1[i];
      d2[i] = longint'($signed(c[9+i])) - p2[i];
      rv[i] = p1[i] - p2[i];
    end
    a = dot3(d1, d1);
    e = dot3(d2, d2);
    f = dot3(d2, rv);
    cc = dot3(d1, rv);
    b = dot3(d1, d2);
    dega = a <= wide_t'(thr);
    dege = e <= wide_t'(thr);
    s = '0;
    t = '0;
    if (dega && dege) begin
      s = '0;
    end else if (dega) begin
      t = clamp_quot(f, e);
    end else if (dege) begin
      s = clamp_quot(-cc, a);
    end else begin
      den = a * e - b * b;
      s = (den > 0) ? clamp_quot(b * f - cc * e, den) : '0;
      tn = b * wide_t'(s) + (f <<< FracW);
      td = e <<< FracW;
      if (tn < 0) begin
        t = '0;
        s = clamp_quot(-cc, a);
      end else if (tn > td) begin
        t = ParOne;
        s = clamp_quot(b - cc, a);
      end else begin
        t = clamp_quot(tn, td);
      end
    end
    for (int i = 0; i < 3; i++) begin
      n1[i] = p1[i] + (d1[i] * longint'(s)) / (longint'(1) <<< FracW);
      n2[i] = p2[i] + (d2[i] * longint'(t)) / (longint'(1) <<< FracW);
      df[i] = n1[i] - n2[i];
      r.near[i]   = n1[i][CoordW-1:0];
      r.near[3+i] = n2[i][CoordW-1:0];
    end
    dd = dot3(df, df);
    if (dd > wide_t'({DistW{1'b1}})) r.dsq = '1;
    else r.dsq = dd[DistW-1:0];
    r.s = s;
    r.t = t;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    closest_t want;
    if (!rst_ni) begin
      thr_q        <= '0;
      fail_count_o = 0;
      closest_q.delete();
    end else begin
      if (done_i) begin
        if (closest_q.size() == 0) begin
          report_mismatch("unexpected result", dist_sq_i, 0);
        end else begin
          want = closest_q.pop_front();
          if (dist_sq_i !== want.dsq) report_mismatch("dist_sq", dist_sq_i, want.dsq);
          for (int i = 0; i < 6; i++)
            if (near_i[i] !== want.near[i])
              report_mismatch($sformatf("near%0d[%0d]", i / 3 + 1, i % 3),
                              near_i[i], want.near[i]);
          if (param_s_i !== want.s) report_mismatch("param_s", param_s_i, want.s);
          if (param_t_i !== want.t) report_mismatch("param_t", param_t_i, want.t);
        end
      end
      if (start && !busy) closest_q.push_back(predict_closest(pair_i, thr_q));
      if (cfg_valid_i && cfg_ready_i) thr_q <= cfg_data_i;
    end
  end

endmodule

// ----- tb/segment_segment_closest_points_unit_tb.sv -----
// Top of the testbench for segment_segment_closest_points_unit: clock, reset,
// segment pair and threshold stimulus, verdict. Depends on sscp_pkg and
// sscp_scoreboard.
`timescale 1ns / 1ps

module segment_segment_closest_points_unit_tb;

  localparam int CoordW = sscp_pkg::CoordW;
  localparam int ThrW   = sscp_pkg::ThrW;
  localparam int DistW  = sscp_pkg::DistW;
  localparam int ParW   = sscp_pkg::ParW;
  localparam int Latency = 60;

  logic clk_i, rst_ni, start, busy;
  logic [11:0][CoordW-1:0] pair;
  logic cfg_valid_i, cfg_ready_o;
  logic [ThrW-1:0] cfg_data_i;
  logic done_o;
  logic [DistW-1:0] dist_sq_o;
  logic [5:0][CoordW-1:0] near;
  logic [ParW-1:0] param_s_o, param_t_o;
  int fail_count, pending;
  bit quiet;

  segment_segment_closest_points_unit i_dut (
    .clk_i, .rst_ni, .start, .busy,
    .p1_x_i(pair[0]), .p1_y_i(pair[1]), .p1_z_i(pair[2]),
    .q1_x_i(pair[3]), .q1_y_i(pair[4]), .q1_z_i(pair[5]),
    .p2_x_i(pair[6]), .p2_y_i(pair[7]), .p2_z_i(pair[8]),
    .q2_x_i(pair[9]), .q2_y_i(pair[10]), .q2_z_i(pair[11]),
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .done_o, .dist_sq_o,
    .near1_x_o(near[0]), .near1_y_o(near[1]), .near1_z_o(near[2]),
    .near2_x_o(near[3]), .near2_y_o(near[4]), .near2_z_o(near[5]),
    .param_s_o, .param_t_o
  );

  sscp_scoreboard i_scoreboard (
    .clk_i, .rst_ni, .start, .busy, .pair_i(pair),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .done_i(done_o), .dist_sq_i(dist_sq_o), .near_i(near),
    .param_s_i(param_s_o), .param_t_i(param_t_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 1_000_000);
    $display("segment_segment_closest_points_unit: mismatch");
    $finish;
  end

  function automatic logic [CoordW-1:0] any_coord();
    return CoordW'($urandom());
  endfunction

  function automatic logic [CoordW-1:0] near_coord(logic [CoordW-1:0] base, int span);
    return base + CoordW'($urandom_range(2 * span) - span);
  endfunction

  // one pair of a randomly chosen shape
  function automatic logic [11:0][CoordW-1:0] random_pair();
    logic [11:0][CoordW-1:0] r;
    int k;
    for (int i = 0; i < 12; i++) r[i] = any_coord();
    case ($urandom_range(7))
      0, 1: ;
      2: for (int i = 0; i < 12; i++) r[i] = near_coord('0, 1 << 14);
      3: for (int i = 0; i < 3; i++) r[3+i] = near_coord(r[i], 700);
      4: for (int i = 0; i < 3; i++) r[9+i] = near_coord(r[6+i], 700);
      5: for (int i = 0; i < 3; i++) begin
        r[3+i] = near_coord(r[i], 700);
        r[9+i] = near_coord(r[6+i], 700);
      end
      default: begin
        // parallel or anti-parallel, small coordinates
        k = $urandom_range(1);
        for (int i = 0; i < 3; i++) begin
          r[i]   = near_coord('0, 1 << 20);
          r[3+i] = near_coord('0, 1 << 20);
          r[6+i] = near_coord('0, 1 << 20);
          r[9+i] = k ? r[6+i] + (r[3+i] - r[i]) : r[6+i] - (r[3+i] - r[i]);
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_pair(logic [11:0][CoordW-1:0] v);
    @(negedge clk_i);
    pair  <= v;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic maybe_idle();
    int n;
    if (!quiet && $urandom_range(5) == 0) begin
      n = $urandom_range(1, 14);
      repeat (n) begin
        @(negedge clk_i);
        start <= 1'b0;
      end
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [ThrW-1:0] v);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [11:0][CoordW-1:0] v;
    logic [ThrW-1:0] thr_set[5];
    localparam logic [CoordW-1:0] CMax = {1'b0, {(CoordW-1){1'b1}}};
    localparam logic [CoordW-1:0] CMin = {1'b1, {(CoordW-1){1'b0}}};
    rst_ni = 1'b0;
    start = 1'b0;
    pair = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    quiet = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, degenerate cases, parallel, clamps
    send_pair('0);
    send_pair({12{CMax}});
    send_pair({12{CMin}});
    send_pair({{6{CMax}}, {6{CMin}}});
    send_pair({{3{CMax}}, {3{CMin}}, {3{CMin}}, {3{CMax}}});
    send_pair({{3{CMin}}, {3{CMax}}, {3{CMax}}, {3{CMin}}});
    v = '0; v[3] = CMax; v[6] = CMin; v[9] = CMin; v[10] = CMax;
    send_pair(v);
    v = '0; v[3] = 24'd4096; v[9] = 24'd4096; v[8] = 24'd4096; v[11] = 24'd4096;
    send_pair(v);                                   // parallel
    v = '0; v[3] = 24'd8192; v[7] = -24'sd4096; v[10] = 24'd4096;
    v[6] = 24'd4096; v[9] = 24'd4096; v[8] = 24'd100; v[11] = 24'd100;
    send_pair(v);                                   // perpendicular crossing
    v = '0; v[6] = 24'd4096; v[9] = 24'd8192; v[10] = 24'd4096;
    send_pair(v);                                   // first degenerate
    v = '0; v[3] = 24'd8192; v[6] = 24'd4096; v[7] = 24'd4096;
    v[9] = 24'd4096; v[10] = 24'd4096;
    send_pair(v);                                   // second degenerate
    v = '0; v[3] = 24'd4096; v[6] = 24'd40000; v[7] = 24'd4096;
    v[9] = 24'd50000; v[10] = 24'd8192;
    send_pair(v);                                   // t clamps below zero
    v = '0; v[3] = 24'd4096; v[6] = -24'sd40000; v[7] = 24'd4096;
    v[9] = -24'sd9000; v[10] = 24'd8192;
    send_pair(v);                                   // t clamps above one
    v = '0; v[3] = 24'd1; v[9] = 24'd1; v[6] = 24'd3;
    send_pair(v);

    thr_set = '{20'd0, 20'hFFFFF, 20'd0, 20'd1000, 20'd0};
    thr_set[2] = ThrW'($urandom());
    for (int ph = 0; ph < 5; ph++) begin
      write_threshold(thr_set[ph]);
      quiet = (ph == 4);
      for (int n = 0; n < 330; n++) begin
        send_pair(random_pair());
        maybe_idle();
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("segment_segment_closest_points_unit: match");
    end else begin
      $display("segment_segment_closest_points_unit: mismatch");
    end
    $finish;
  end

endmodule
